FILE: rtl/idsa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_pkg
// shared types, codes and sizing helpers of the insert/delete shift array
// ----------------------------------------------------------------------------
package idsa_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_WORD_WIDTH = 32;

    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 7;

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_INSERT = 2'd1,
        OP_DELETE = 2'd2,
        OP_READ   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        op_t                       command;
        logic [POS_W-1:0]          position;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
        logic [COUNT_W-1:0]        count;
        logic                      is_empty;
    } rsp_t;

    // address bits for a store of the given depth
    function automatic int addr_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

    // bits to hold an element count from zero to depth
    function automatic int count_width(input int depth);
        return $clog2(depth + 1);
    endfunction

endpackage

FILE: rtl/idsa_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_mem
// element store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module idsa_mem #(
    parameter int CAPACITY   = idsa_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = idsa_pkg::DEF_WORD_WIDTH
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [idsa_pkg::addr_width(CAPACITY)-1:0]     waddr,
    input  logic [WORD_WIDTH-1:0]                         wdata,
    input  logic [idsa_pkg::addr_width(CAPACITY)-1:0]     raddr,
    output logic [WORD_WIDTH-1:0]                         rdata
);
    import idsa_pkg::*;

    logic [WORD_WIDTH-1:0] mem_array [CAPACITY];
    logic [WORD_WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_array[waddr] <= wdata;
        end
        rdata_reg <= mem_array[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/idsa_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idsa_seq
// command sequencer: bounds checks, element count, and the shared index
// step unit that walks the store one move at a time
// ----------------------------------------------------------------------------
module idsa_seq #(
    parameter int CAPACITY   = idsa_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = idsa_pkg::DEF_WORD_WIDTH
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      req_valid,
    input  idsa_pkg::req_t                            req,
    output logic                                      req_stall,
    output logic                                      fin_valid,
    input  logic                                      fin_ready,
    output idsa_pkg::rsp_t                            fin,
    output logic                                      mem_we,
    output logic [idsa_pkg::addr_width(CAPACITY)-1:0] mem_waddr,
    output logic [WORD_WIDTH-1:0]                     mem_wdata,
    output logic [idsa_pkg::addr_width(CAPACITY)-1:0] mem_raddr,
    input  logic [WORD_WIDTH-1:0]                     mem_rdata
);
    import idsa_pkg::*;

    localparam int AW = addr_width(CAPACITY);
    localparam int CW = count_width(CAPACITY);
    localparam int MW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [5:0] {
        S_IDLE    = 6'b000001,
        S_MV_RD   = 6'b000010,
        S_MV_WR   = 6'b000100,
        S_INS_WR  = 6'b001000,
        S_RD_WAIT = 6'b010000,
        S_FINISH  = 6'b100000
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [AW-1:0]             stop_reg, stop_next;
    op_t                       op_reg, op_next;
    logic [WORD_WIDTH-1:0]     value_reg, value_next;
    status_t                   status_reg, status_next;
    logic signed [VALUE_W-1:0] rd_value_reg, rd_value_next;

    logic [AW-1:0]             step;
    logic [WORD_WIDTH-1:0]     val_w;
    logic [VALUE_W-1:0]        rd_ext;
    logic [MW-1:0]             pos_m;
    logic [MW-1:0]             cnt_m;
    logic                      full;

    // shared index unit: one position up for delete, one down for insert
    assign step = (op_reg == OP_INSERT) ? (idx_reg - AW'(1)) : (idx_reg + AW'(1));

    assign pos_m = MW'(req.position);
    assign cnt_m = MW'(count_reg);
    assign full  = (count_reg == CW'(CAPACITY));

    // incoming word sign extended, then cut to the stored width
    always_comb
    begin
        for (int b = 0; b < WORD_WIDTH; b++)
        begin
            val_w[b] = req.value[(b < VALUE_W) ? b : VALUE_W - 1];
        end
    end

    // stored word sign extended back to the result width
    always_comb
    begin
        for (int b = 0; b < VALUE_W; b++)
        begin
            rd_ext[b] = mem_rdata[(b < WORD_WIDTH) ? b : WORD_WIDTH - 1];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        stop_next     = stop_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        rd_value_next = rd_value_reg;
        mem_we        = 1'b0;
        mem_waddr     = idx_reg;
        mem_wdata     = value_reg;
        mem_raddr     = step;

        unique case (state_reg)
            S_IDLE:
            begin
                mem_raddr = AW'(req.position);
                if (req_valid)
                begin
                    op_next       = req.command;
                    value_next    = val_w;
                    rd_value_next = '0;
                    status_next   = ST_OK;
                    idx_next      = AW'(count_reg);
                    stop_next     = AW'(req.position);
                    state_next    = S_FINISH;
                    case (req.command)
                        OP_PUSH:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                mem_we     = 1'b1;
                                mem_waddr  = AW'(count_reg);
                                mem_wdata  = val_w;
                                count_next = count_reg + CW'(1);
                            end
                        end
                        OP_INSERT:
                        begin
                            if (pos_m > cnt_m)
                            begin
                                status_next = ST_RANGE;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (pos_m == cnt_m)
                            begin
                                state_next = S_INS_WR;
                            end
                            else
                            begin
                                state_next = S_MV_RD;
                            end
                        end
                        OP_DELETE:
                        begin
                            if (pos_m >= cnt_m)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                idx_next  = AW'(req.position);
                                stop_next = AW'(count_reg - CW'(1));
                                if (pos_m + MW'(1) == cnt_m)
                                begin
                                    count_next = count_reg - CW'(1);
                                end
                                else
                                begin
                                    state_next = S_MV_RD;
                                end
                            end
                        end
                        OP_READ:
                        begin
                            if (pos_m >= cnt_m)
                            begin
                                status_next = ST_RANGE;
                            end
                            else
                            begin
                                state_next = S_RD_WAIT;
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_MV_RD:
            begin
                state_next = S_MV_WR;
            end
            S_MV_WR:
            begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = mem_rdata;
                idx_next  = step;
                if (step == stop_reg)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        state_next = S_INS_WR;
                    end
                    else
                    begin
                        count_next = count_reg - CW'(1);
                        state_next = S_FINISH;
                    end
                end
                else
                begin
                    state_next = S_MV_RD;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = idx_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                state_next = S_FINISH;
            end
            S_RD_WAIT:
            begin
                rd_value_next = rd_ext;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                if (fin_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        stop_reg     <= stop_next;
        op_reg       <= op_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        rd_value_reg <= rd_value_next;
    end

    assign req_stall      = (state_reg != S_IDLE);
    assign fin_valid      = (state_reg == S_FINISH);
    assign fin.read_value = rd_value_reg;
    assign fin.status     = status_reg;
    assign fin.count      = COUNT_W'(count_reg);
    assign fin.is_empty   = (count_reg == '0);

endmodule

FILE: rtl/insert_delete_shift_array.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insert_delete_shift_array
// ordered array of signed words with push, insert, delete and read commands
// ----------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall / req carries one command with its
//   position and value; a request is taken when req_valid is high and
//   req_stall is low. req_stall stays high from the request until its result
//   has moved into the result register, so one command is in flight at once.
//   result channel: rsp_valid / rsp_stall / rsp carries one result per
//   request: read word, status, element count and empty flag.
//   sequence: push, or any command that fails its check, goes straight to
//   the finish state; read passes a wait state for the registered store
//   data; insert shifts the entries from the end down to position p, then
//   writes the new word; delete shifts the entries above p down by one.
//   each shifted entry costs a read state then a write state on the store;
//   the next request is taken in the cycle after the result is handed over.
//   reset clears the element count and all handshake state; store contents
//   are not cleared, only entries below the count are ever read.
//   while rsp_stall holds a result, the sequencer may take one more request;
//   when that command finishes it waits in the sequencer and no further
//   request is taken until the result register frees.
// ----------------------------------------------------------------------------
module insert_delete_shift_array #(
    parameter int CAPACITY   = idsa_pkg::DEF_CAPACITY,
    parameter int WORD_WIDTH = idsa_pkg::DEF_WORD_WIDTH
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  idsa_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output idsa_pkg::rsp_t rsp
);
    import idsa_pkg::*;

    localparam int AW = addr_width(CAPACITY);

    // sequencer to result register
    logic                  fin_valid;
    logic                  fin_ready;
    rsp_t                  fin;

    // store port
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [WORD_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [WORD_WIDTH-1:0] mem_rdata;

    // result register
    logic                  rsp_valid_reg;
    rsp_t                  rsp_reg;

    idsa_seq #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .fin_valid (fin_valid),
        .fin_ready (fin_ready),
        .fin       (fin),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata)
    );

    idsa_mem #(
        .CAPACITY   (CAPACITY),
        .WORD_WIDTH (WORD_WIDTH)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // result slot frees when empty or when the receiver takes it this cycle
    assign fin_ready = !rsp_valid_reg || !rsp_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (fin_valid && fin_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // payload only loads on hand-over, so a stalled result holds
    always_ff @(posedge clk)
    begin
        if (fin_valid && fin_ready)
        begin
            rsp_reg <= fin;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTH
    // a taken request blocks the next one
    a_req_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while a command is in flight");

    // failed commands return a zero word
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK) |-> rsp.read_value == '0)
        else $error("failed command returned a nonzero word");

    // a full report never comes with an empty array
    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == ST_FULL) |-> !rsp.is_empty)
        else $error("full status with empty array");

    // a result only appears after a request was in flight
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result without a request in flight");
`endif

endmodule

FILE: bench/insert_delete_shift_array_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// insert_delete_shift_array_tb
// self-checking bench for the insert/delete shift array: a directed pass over
// the empty, boundary and out-of-range cases, then random command episodes
// that steer the element count toward chosen levels, full and empty among
// them, with random gaps on the request side and random stalls on the result
// side; every result is checked field by field against a software copy
// ----------------------------------------------------------------------------
module insert_delete_shift_array_tb;

    import idsa_pkg::*;

    localparam int CAPACITY     = DEF_CAPACITY;
    localparam int RANDOM_ITEMS = 1030;
    // worst command is an insert at 0 into a full-but-one array, plus a
    // random gap and a random stall per request
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 150;

    // ------------------------------------------------------------------------
    // scoreboard: keeps its own copy of the array and the expected results
    // ------------------------------------------------------------------------
    class array_scoreboard;
        logic signed [VALUE_W-1:0] words [CAPACITY];
        int   fill;
        rsp_t pending_results [$];
        int   errors;
        int   checked;
        int   status_tally [3];
        int   peak_fill;

        function new();
            fill      = 0;
            errors    = 0;
            checked   = 0;
            peak_fill = 0;
            foreach (status_tally[i]) status_tally[i] = 0;
        endfunction

        // apply one command to the copy and return what the block must answer
        function rsp_t apply_command(req_t r);
            rsp_t res;
            int   p;
            res        = '0;
            res.status = ST_OK;
            p          = r.position;
            case (r.command)
                OP_PUSH:
                    if (fill >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        words[fill] = r.value;
                        fill++;
                    end
                OP_INSERT:
                    // range is checked before fullness
                    if (p > fill)
                        res.status = ST_RANGE;
                    else if (fill >= CAPACITY)
                        res.status = ST_FULL;
                    else
                    begin
                        for (int i = fill; i > p; i--)
                            words[i] = words[i-1];
                        words[p] = r.value;
                        fill++;
                    end
                OP_DELETE:
                    if (p >= fill)
                        res.status = ST_RANGE;
                    else
                    begin
                        for (int i = p; i + 1 < fill; i++)
                            words[i] = words[i+1];
                        fill--;
                    end
                default:
                    if (p >= fill)
                        res.status = ST_RANGE;
                    else
                        res.read_value = words[p];
            endcase
            res.count    = COUNT_W'(fill);
            res.is_empty = (fill == 0);
            return res;
        endfunction

        function void note_request(req_t r);
            rsp_t res;
            res = apply_command(r);
            pending_results.push_back(res);
            status_tally[int'(res.status)]++;
            if (fill > peak_fill)
                peak_fill = fill;
        endfunction

        function void check_result(rsp_t got);
            rsp_t want;
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding: count %0d status %0d",
                       got.count, got.status);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (got.read_value !== want.read_value)
            begin
                $error("read_value expected %0d actual %0d", want.read_value, got.read_value);
                errors++;
            end
            if (got.status !== want.status)
            begin
                $error("status expected %0d actual %0d", want.status, got.status);
                errors++;
            end
            if (got.count !== want.count)
            begin
                $error("count expected %0d actual %0d", want.count, got.count);
                errors++;
            end
            if (got.is_empty !== want.is_empty)
            begin
                $error("is_empty expected %0d actual %0d", want.is_empty, got.is_empty);
                errors++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // clock, reset and the block
    // ------------------------------------------------------------------------
    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    array_scoreboard board;
    bit              calm;        // stretch with no gaps and no stalls
    int              requests_sent;
    int              cycle_count;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    insert_delete_shift_array u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    function automatic req_t make_req(op_t op, int pos, logic [VALUE_W-1:0] val);
        req_t r;
        r.command  = op;
        r.position = POS_W'(pos);
        r.value    = val;
        return r;
    endfunction

    // present one request after a random gap and hold it until it is taken;
    // called at a rising edge, returns at the edge that took the request
    task automatic send_request(req_t r);
        int gap;
        bit taken;
        gap   = calm ? 0 : $urandom_range(0, 7);
        taken = 1'b0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        // stall is stable by the falling edge, so decide there and move on
        while (!taken)
        begin
            @(negedge clk);
            taken = !req_stall;
            @(posedge clk);
        end
        board.note_request(r);
        requests_sent++;
    endtask

    // drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.pending_results.size() != 0);
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // mostly legal positions, with boundaries and the full 7-bit range mixed in
    function automatic int pick_position(op_t op, int level);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 127);
            1:       return level;
            2:       return 0;
            3:       return (level > 0) ? level - 1 : 0;
            default:
                if (op == OP_INSERT || op == OP_PUSH)
                    return $urandom_range(0, level);
                else
                    return (level > 0) ? $urandom_range(0, level - 1) : 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // result side: random stall before each result, then take it
    // ------------------------------------------------------------------------
    initial
    begin
        int   hold;
        bit   seen;
        rsp_t got;
        rsp_stall <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            rsp_stall <= 1'b0;
            seen = 1'b0;
            while (!seen)
            begin
                @(negedge clk);
                seen = rsp_valid;
                got  = rsp;
                @(posedge clk);
            end
            board.check_result(got);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("insert_delete_shift_array_tb: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int   target;
        int   span;
        int   roll;
        int   level;
        op_t  op;
        board         = new();
        calm          = 1'b0;
        requests_sent = 0;
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty array, extremes of the word, append through insert,
        // insert at the head, reads at and past the end, deletes everywhere
        send_request(make_req(OP_READ,   0,   32'h1234_5678));
        send_request(make_req(OP_DELETE, 0,   32'h0));
        send_request(make_req(OP_INSERT, 1,   32'h0000_0001));
        send_request(make_req(OP_INSERT, 0,   32'h8000_0000));
        send_request(make_req(OP_PUSH,   0,   32'h7fff_ffff));
        send_request(make_req(OP_PUSH,   127, 32'h0000_0000));   // position ignored
        send_request(make_req(OP_PUSH,   64,  32'hffff_ffff));
        send_request(make_req(OP_INSERT, 4,   32'h5555_5555));   // equal to count
        send_request(make_req(OP_INSERT, 0,   32'haaaa_aaaa));
        send_request(make_req(OP_INSERT, 2,   32'h0000_3039));
        send_request(make_req(OP_INSERT, 8,   32'h0000_0007));   // one past count
        send_request(make_req(OP_READ,   0,   32'hffff_ffff));   // value ignored
        send_request(make_req(OP_READ,   1,   32'h0));
        send_request(make_req(OP_READ,   6,   32'h0));
        send_request(make_req(OP_READ,   7,   32'h0));           // at count
        send_request(make_req(OP_READ,   127, 32'h0));
        send_request(make_req(OP_READ,   64,  32'h0));
        send_request(make_req(OP_DELETE, 6,   32'h0));           // last entry
        send_request(make_req(OP_DELETE, 2,   32'hdead_beef));
        send_request(make_req(OP_DELETE, 0,   32'h0));
        send_request(make_req(OP_DELETE, 64,  32'h0));
        send_request(make_req(OP_INSERT, 127, 32'h0));
        send_request(make_req(OP_READ,   3,   32'h0));

        // hold off until the block has answered everything
        drain_results();

        // random episodes: steer the count toward a target level; the first
        // episode fills the array so push and insert meet a full store early
        target = CAPACITY;
        span   = 160;
        while (requests_sent < RANDOM_ITEMS + 23)
        begin
            calm = ($urandom_range(0, 4) == 0);
            repeat (span)
            begin
                if (requests_sent < RANDOM_ITEMS + 23)
                begin
                    level = board.fill;
                    roll  = $urandom_range(0, 99);
                    if (roll < 22)
                        op = OP_READ;
                    else if (roll < 26)
                        op = op_t'($urandom_range(0, 3));
                    else if ((level < target && roll < 82) || (level > target && roll >= 82)
                             || (level == target && roll < 60))
                        op = ($urandom_range(0, 1) == 0) ? OP_PUSH : OP_INSERT;
                    else
                        op = OP_DELETE;
                    send_request(make_req(op, pick_position(op, level), pick_value()));
                end
            end
            if ($urandom_range(0, 3) == 0)
                drain_results();
            case ($urandom_range(0, 5))
                0:       target = CAPACITY;
                1:       target = 0;
                2:       target = CAPACITY - 1;
                default: target = $urandom_range(1, CAPACITY - 1);
            endcase
            span = $urandom_range(20, 80);
        end

        // let the last results out, then allow for the longest command
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d requests, %0d results checked, peak count %0d",
                 requests_sent, board.checked, board.peak_fill);
        $display("statuses seen: ok %0d, out of range %0d, full %0d",
                 board.status_tally[0], board.status_tally[1], board.status_tally[2]);
        if (board.errors == 0 && board.pending_results.size() == 0)
            $display("insert_delete_shift_array_tb: clean");
        else
            $display("insert_delete_shift_array_tb: errors");
        $finish;
    end

endmodule
